/* src/ebat_pkg.sv */
// Shared types and constants for the EWMA baseline anomaly table.
// Holds the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package ebat_pkg;

   localparam int MAX_ENTRIES_DEF    = 64;
   localparam int NUM_INDICATORS_DEF = 16;

   // quotient bits of the z score divide: |d| (33 bits) shifted left by 16
   localparam int DIV_W   = 49;
   localparam int DIV_CW  = 6;

   localparam logic [16:0] Q_ONE         = 17'd65536;
   localparam logic [16:0] ALPHA_RST     = 17'd6554;
   localparam logic [31:0] Z_THRESH_RST  = 32'd196608;
   localparam logic [15:0] MIN_DIV_RST   = 16'd7;

   // configuration register indexes
   localparam logic [1:0] CSR_ALPHA   = 2'd0;
   localparam logic [1:0] CSR_ZTHRESH = 2'd1;
   localparam logic [1:0] CSR_MINDIV  = 2'd2;

   typedef enum logic [1:0] {
      KIND_UPDATE = 2'd0,
      KIND_DETECT = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

   // one table entry
   typedef struct packed {
      logic [31:0]        pid;
      logic [7:0]         ind;
      logic signed [31:0] mean;
      logic [31:0]        spread;
      logic [31:0]        count;
      logic [47:0]        tick;
   } entry_type;

   typedef enum logic [1:0] {
      CODE_OK, CODE_INVALID, CODE_NOTFOUND, CODE_DETECT
   } code_type;

   typedef enum logic [2:0] {
      MUL_AS, MUL_BM, MUL_DD, MUL_ASQ, MUL_BSP
   } mul_op_type;

   typedef enum logic [1:0] {
      ACC_NONE, ACC_LOAD, ACC_MEAN, ACC_SQ
   } acc_op_type;

   typedef enum logic [1:0] {
      RD_SCAN, RD_RMK, RD_LAST
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_UPD, WR_INS, WR_COPY
   } wr_sel_type;

   typedef enum logic [1:0] {
      WA_HIT, WA_USED, WA_OLD, WA_RMK
   } wr_at_type;

   typedef enum logic [1:0] {
      USED_HOLD, USED_INC, USED_DEC, USED_CLR
   } used_op_type;

   typedef struct packed {
      logic        load_req;
      logic        scan_clr;
      logic        scan_issue;
      rd_sel_type  rd_sel;
      mul_op_type  mul_op;
      acc_op_type  acc_op;
      logic        mem_we;
      wr_sel_type  wr_sel;
      wr_at_type   wr_at;
      used_op_type used_op;
      logic        rmk_clr;
      logic        rmk_inc;
      logic        div_start;
      logic        div_step;
      logic        code_we;
      code_type    code;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      kind_type kind_in;
      logic     key_ok_in;
      logic     pid_ok_in;
      kind_type kind;
      logic     empty;
      logic     full;
      logic     hit;
      logic     scan_last;
      logic     div_last;
      logic     rm_done;
      logic     rm_match;
      logic     rm_last;
      logic     rsp_free;
   } stat_type;

endpackage

/* src/ebat_ctrl.sv */
// Controller state machine for the EWMA baseline anomaly table.
// Sequences search, update, insert, divide, remove and clear through ebat_dp.
// Depends on ebat_pkg.
`timescale 1ns / 1ps

module ebat_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ebat_pkg::stat_type stat,
   output ebat_pkg::cmd_type  cmd
);

   typedef enum logic [19:0] {
      S_IDLE   = 20'h00001,
      S_SCAN   = 20'h00002,
      S_U1     = 20'h00004,
      S_U2     = 20'h00008,
      S_U3     = 20'h00010,
      S_U4     = 20'h00020,
      S_U5     = 20'h00040,
      S_U6     = 20'h00080,
      S_U7     = 20'h00100,
      S_U8     = 20'h00200,
      S_INS    = 20'h00400,
      S_DSTART = 20'h00800,
      S_DIV    = 20'h01000,
      S_RM_RD  = 20'h02000,
      S_RM_CMP = 20'h04000,
      S_RM_RDL = 20'h08000,
      S_RM_WR  = 20'h10000,
      S_RESP   = 20'h20000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.rd_sel  = ebat_pkg::RD_SCAN;
      cmd.mul_op  = ebat_pkg::MUL_AS;
      cmd.acc_op  = ebat_pkg::ACC_NONE;
      cmd.wr_sel  = ebat_pkg::WR_UPD;
      cmd.wr_at   = ebat_pkg::WA_HIT;
      cmd.used_op = ebat_pkg::USED_HOLD;
      cmd.code    = ebat_pkg::CODE_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.scan_clr = 1'b1;
               cmd.code_we  = 1'b1;
               unique case (stat.kind_in)
                  ebat_pkg::KIND_UPDATE, ebat_pkg::KIND_DETECT: begin
                     if (stat.key_ok_in) begin
                        state_in = S_SCAN;
                     end else begin
                        cmd.code = ebat_pkg::CODE_INVALID;
                        state_in = S_RESP;
                     end
                  end
                  ebat_pkg::KIND_REMOVE: begin
                     cmd.rmk_clr = 1'b1;
                     if (stat.pid_ok_in) begin
                        state_in = S_RM_RD;
                     end else begin
                        cmd.code = ebat_pkg::CODE_INVALID;
                        state_in = S_RESP;
                     end
                  end
                  ebat_pkg::KIND_CLEAR: begin
                     cmd.used_op = ebat_pkg::USED_CLR;
                     state_in    = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.hit) begin
               state_in = (stat.kind == ebat_pkg::KIND_UPDATE) ? S_U1 : S_DSTART;
            end else if (stat.empty || stat.scan_last) begin
               if (stat.kind == ebat_pkg::KIND_UPDATE) begin
                  state_in = S_INS;
               end else begin
                  cmd.code_we = 1'b1;
                  cmd.code    = ebat_pkg::CODE_NOTFOUND;
                  state_in    = S_RESP;
               end
            end
         end
         // mean: a*s + (1-a)*mean
         S_U1: begin
            cmd.mul_op = ebat_pkg::MUL_AS;
            state_in   = S_U2;
         end
         S_U2: begin
            cmd.mul_op = ebat_pkg::MUL_BM;
            cmd.acc_op = ebat_pkg::ACC_LOAD;
            state_in   = S_U3;
         end
         S_U3: begin
            cmd.acc_op = ebat_pkg::ACC_MEAN;
            state_in   = S_U4;
         end
         // squared deviation from the new mean
         S_U4: begin
            cmd.mul_op = ebat_pkg::MUL_DD;
            state_in   = S_U5;
         end
         S_U5: begin
            cmd.acc_op = ebat_pkg::ACC_SQ;
            state_in   = S_U6;
         end
         // spread: a*sq + (1-a)*spread
         S_U6: begin
            cmd.mul_op = ebat_pkg::MUL_ASQ;
            state_in   = S_U7;
         end
         S_U7: begin
            cmd.mul_op = ebat_pkg::MUL_BSP;
            cmd.acc_op = ebat_pkg::ACC_LOAD;
            state_in   = S_U8;
         end
         S_U8: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = ebat_pkg::WR_UPD;
            cmd.wr_at  = ebat_pkg::WA_HIT;
            state_in   = S_RESP;
         end
         S_INS: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = ebat_pkg::WR_INS;
            if (stat.full) begin
               cmd.wr_at = ebat_pkg::WA_OLD;
            end else begin
               cmd.wr_at   = ebat_pkg::WA_USED;
               cmd.used_op = ebat_pkg::USED_INC;
            end
            state_in = S_RESP;
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               cmd.code_we = 1'b1;
               cmd.code    = ebat_pkg::CODE_DETECT;
               state_in    = S_RESP;
            end
         end
         // remove: read entry k, on a match move the last entry in
         S_RM_RD: begin
            cmd.rd_sel = ebat_pkg::RD_RMK;
            state_in   = stat.rm_done ? S_RESP : S_RM_CMP;
         end
         S_RM_CMP: begin
            if (!stat.rm_match) begin
               cmd.rmk_inc = 1'b1;
               state_in    = S_RM_RD;
            end else if (stat.rm_last) begin
               cmd.used_op = ebat_pkg::USED_DEC;
               state_in    = S_RM_RD;
            end else begin
               state_in = S_RM_RDL;
            end
         end
         S_RM_RDL: begin
            cmd.rd_sel = ebat_pkg::RD_LAST;
            state_in   = S_RM_WR;
         end
         S_RM_WR: begin
            cmd.mem_we  = 1'b1;
            cmd.wr_sel  = ebat_pkg::WR_COPY;
            cmd.wr_at   = ebat_pkg::WA_RMK;
            cmd.used_op = ebat_pkg::USED_DEC;
            state_in    = S_RM_RD;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // an accepted item always takes the block out of idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held after accept");

   // a response is only loaded when the output register can take it
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.rsp_free)
      else $error("response loaded over a waiting item");

endmodule

/* src/ebat_dp.sv */
// Datapath for the EWMA baseline anomaly table: entry memory, key scan,
// shared multiplier, radix-2 divider, config and output registers.
// Depends on ebat_pkg.
`timescale 1ns / 1ps

module ebat_dp #(
   parameter int MAX_ENTRIES    = ebat_pkg::MAX_ENTRIES_DEF,
   parameter int NUM_INDICATORS = ebat_pkg::NUM_INDICATORS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ebat_pkg::cmd_type  cmd,
   output ebat_pkg::stat_type stat,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic [1:0]         req_kind,
   input  logic [31:0]        req_process_id,
   input  logic [7:0]         req_indicator,
   input  logic signed [31:0] req_sample,
   input  logic [47:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output logic               rsp_anomaly,
   output logic signed [31:0] rsp_z_score,
   output logic signed [31:0] rsp_mean_out,
   output logic [31:0]        rsp_spread_out,
   output logic [31:0]        rsp_count_out,
   output logic [47:0]        rsp_tick_out
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

   // configuration
   logic [16:0] alpha_ff;
   logic [31:0] zthr_ff;
   logic [15:0] mindiv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ebat_pkg::ALPHA_RST;
         zthr_ff   <= ebat_pkg::Z_THRESH_RST;
         mindiv_ff <= ebat_pkg::MIN_DIV_RST;
      end else if (csr_we) begin
         if (csr_index == ebat_pkg::CSR_ALPHA)   alpha_ff  <= csr_wdata[16:0];
         if (csr_index == ebat_pkg::CSR_ZTHRESH) zthr_ff   <= csr_wdata;
         if (csr_index == ebat_pkg::CSR_MINDIV)  mindiv_ff <= csr_wdata[15:0];
      end
   end

   logic [16:0] a_eff, b_eff;
   assign a_eff = (alpha_ff > ebat_pkg::Q_ONE) ? ebat_pkg::Q_ONE : alpha_ff;
   assign b_eff = ebat_pkg::Q_ONE - a_eff;

   // captured request
   ebat_pkg::kind_type kind_ff;
   logic [31:0]        pid_ff;
   logic [7:0]         ind_ff;
   logic signed [31:0] smp_ff;
   logic [47:0]        now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= ebat_pkg::kind_type'(req_kind);
         pid_ff  <= req_process_id;
         ind_ff  <= req_indicator;
         smp_ff  <= req_sample;
         now_ff  <= req_now_ms;
      end
   end

   // fill count
   logic [CW-1:0] used_ff;
   logic [AW-1:0] last_addr;
   assign last_addr = AW'(used_ff - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         unique case (cmd.used_op)
            ebat_pkg::USED_HOLD: used_ff <= used_ff;
            ebat_pkg::USED_INC:  used_ff <= used_ff + CW'(1);
            ebat_pkg::USED_DEC:  used_ff <= used_ff - CW'(1);
            ebat_pkg::USED_CLR:  used_ff <= '0;
         endcase
      end
   end

   // entry memory, registered read
   ebat_pkg::entry_type mem [MAX_ENTRIES];
   ebat_pkg::entry_type rdata_ff, wdata;
   logic [AW-1:0]       rd_addr, wr_addr;

   logic [CW-1:0] scan_idx_ff, rmk_ff;
   logic [AW-1:0] hit_idx_ff, old_idx_ff, cmp_idx_ff;

   always_comb begin
      unique case (cmd.rd_sel)
         ebat_pkg::RD_SCAN: rd_addr = scan_idx_ff[AW-1:0];
         ebat_pkg::RD_RMK:  rd_addr = rmk_ff[AW-1:0];
         ebat_pkg::RD_LAST: rd_addr = last_addr;
         default:           rd_addr = scan_idx_ff[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) mem[wr_addr] <= wdata;
      rdata_ff <= mem[rd_addr];
   end

   // key scan, one compare per cycle, oldest tick tracked on the way
   logic                scan_go, cmp_vld_ff, key_eq;
   ebat_pkg::entry_type hit_ent_ff;
   logic [47:0]         old_tick_ff;

   assign scan_go = cmd.scan_issue && (scan_idx_ff < used_ff);
   assign key_eq  = (rdata_ff.pid == pid_ff) && (rdata_ff.ind == ind_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= scan_go;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_clr) begin
         scan_idx_ff <= '0;
      end else if (scan_go) begin
         scan_idx_ff <= scan_idx_ff + CW'(1);
      end
      cmp_idx_ff <= scan_idx_ff[AW-1:0];
      if (cmp_vld_ff && key_eq) begin
         hit_idx_ff <= cmp_idx_ff;
         hit_ent_ff <= rdata_ff;
      end
      if (cmp_vld_ff && (cmp_idx_ff == '0 || rdata_ff.tick < old_tick_ff)) begin
         old_idx_ff  <= cmp_idx_ff;
         old_tick_ff <= rdata_ff.tick;
      end
   end

   // remove cursor
   always_ff @(posedge clock) begin
      if (cmd.rmk_clr) begin
         rmk_ff <= '0;
      end else if (cmd.rmk_inc) begin
         rmk_ff <= rmk_ff + CW'(1);
      end
   end

   // shared multiplier, product registered
   logic signed [33:0] op_a, op_b;
   logic signed [67:0] prod_ff, acc_ff;
   logic signed [32:0] dev;
   logic [32:0]        adev;
   logic signed [31:0] nm_ff;
   logic [31:0]        sq_ff;

   assign dev  = 33'(smp_ff) - 33'(nm_ff);
   assign adev = dev[32] ? 33'(-dev) : 33'(dev);

   always_comb begin
      unique case (cmd.mul_op)
         ebat_pkg::MUL_AS:  begin op_a = {17'b0, a_eff}; op_b = 34'(smp_ff);           end
         ebat_pkg::MUL_BM:  begin op_a = {17'b0, b_eff}; op_b = 34'(hit_ent_ff.mean);  end
         ebat_pkg::MUL_DD:  begin op_a = {1'b0, adev};   op_b = {1'b0, adev};          end
         ebat_pkg::MUL_ASQ: begin op_a = {17'b0, a_eff}; op_b = {2'b0, sq_ff};         end
         ebat_pkg::MUL_BSP: begin op_a = {17'b0, b_eff}; op_b = {2'b0, hit_ent_ff.spread}; end
         default:           begin op_a = '0;             op_b = '0;                    end
      endcase
   end

   logic signed [67:0] sum_r, mean_sh, sq_sh, sp_sh;
   assign sum_r   = acc_ff + prod_ff + 68'sd32768;
   assign mean_sh = sum_r >>> 16;
   assign sq_sh   = (prod_ff + 68'sd32768) >>> 16;
   assign sp_sh   = sum_r >>> 16;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      unique case (cmd.acc_op)
         ebat_pkg::ACC_NONE: ;
         ebat_pkg::ACC_LOAD: acc_ff <= prod_ff;
         ebat_pkg::ACC_MEAN: begin
            if (mean_sh > 68'sh7FFFFFFF)         nm_ff <= 32'sh7FFFFFFF;
            else if (mean_sh < -68'sh80000000)   nm_ff <= 32'sh80000000;
            else                                 nm_ff <= mean_sh[31:0];
         end
         ebat_pkg::ACC_SQ: begin
            sq_ff <= (sq_sh > 68'shFFFFFFFF) ? 32'hFFFFFFFF : sq_sh[31:0];
         end
      endcase
   end

   // write data and address
   logic [31:0] sp_sat, cnt_inc;
   assign sp_sat  = (sp_sh > 68'shFFFFFFFF) ? 32'hFFFFFFFF : sp_sh[31:0];
   assign cnt_inc = (hit_ent_ff.count == 32'hFFFFFFFF) ? hit_ent_ff.count
                                                       : hit_ent_ff.count + 32'd1;

   always_comb begin
      unique case (cmd.wr_sel)
         ebat_pkg::WR_UPD:  wdata = '{pid: pid_ff, ind: ind_ff, mean: nm_ff,
                                      spread: sp_sat, count: cnt_inc, tick: now_ff};
         ebat_pkg::WR_INS:  wdata = '{pid: pid_ff, ind: ind_ff, mean: smp_ff,
                                      spread: 32'd0, count: 32'd1, tick: now_ff};
         ebat_pkg::WR_COPY: wdata = rdata_ff;
         default:           wdata = rdata_ff;
      endcase
      unique case (cmd.wr_at)
         ebat_pkg::WA_HIT:  wr_addr = hit_idx_ff;
         ebat_pkg::WA_USED: wr_addr = used_ff[AW-1:0];
         ebat_pkg::WA_OLD:  wr_addr = old_idx_ff;
         ebat_pkg::WA_RMK:  wr_addr = rmk_ff[AW-1:0];
      endcase
   end

   // restoring divider for the z score: one quotient bit per cycle
   logic signed [32:0]              zdev;
   logic [32:0]                     zmag;
   logic                            use_sp, use_mn;
   logic [31:0]                     rem_ff, dvs_ff;
   logic [ebat_pkg::DIV_W-1:0]      dvd_ff;
   logic [ebat_pkg::DIV_CW-1:0]     div_cnt_ff;
   logic                            neg_ff;
   logic [32:0]                     trial;
   logic                            ge;

   assign zdev   = 33'(smp_ff) - 33'(hit_ent_ff.mean);
   assign zmag   = zdev[32] ? 33'(-zdev) : 33'(zdev);
   assign use_sp = hit_ent_ff.spread > {16'b0, mindiv_ff};
   assign use_mn = hit_ent_ff.mean > $signed({16'b0, mindiv_ff});
   assign trial  = {rem_ff, dvd_ff[ebat_pkg::DIV_W-1]};
   assign ge     = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff     <= '0;
         div_cnt_ff <= '0;
         neg_ff     <= zdev[32];
         if (use_sp) begin
            dvs_ff <= hit_ent_ff.spread;
            dvd_ff <= {zmag, 16'b0};
         end else if (use_mn) begin
            dvs_ff <= hit_ent_ff.mean;
            dvd_ff <= {zmag, 16'b0};
         end else begin
            dvs_ff <= 32'd1;
            dvd_ff <= '0;
         end
      end else if (cmd.div_step) begin
         rem_ff     <= ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
         dvd_ff     <= {dvd_ff[ebat_pkg::DIV_W-2:0], ge};
         div_cnt_ff <= div_cnt_ff + ebat_pkg::DIV_CW'(1);
      end
   end

   // saturate and sign the quotient
   logic signed [31:0] zs;
   logic [32:0]        az;
   always_comb begin
      if (!neg_ff) begin
         zs = (dvd_ff > ebat_pkg::DIV_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : dvd_ff[31:0];
      end else begin
         zs = (dvd_ff > ebat_pkg::DIV_W'(33'h080000000)) ? 32'sh80000000
                                                         : 32'(-dvd_ff[31:0]);
      end
      az = zs[31] ? 33'(-33'(zs)) : 33'(zs);
   end

   // result code and output register
   ebat_pkg::code_type code_ff;
   logic               rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.code_we) code_ff <= cmd.code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_found      <= 1'b0;
         rsp_anomaly    <= 1'b0;
         rsp_z_score    <= '0;
         rsp_mean_out   <= '0;
         rsp_spread_out <= '0;
         rsp_count_out  <= '0;
         rsp_tick_out   <= '0;
         unique case (code_ff)
            ebat_pkg::CODE_OK:       rsp_status <= ebat_pkg::STATUS_OK;
            ebat_pkg::CODE_INVALID:  rsp_status <= ebat_pkg::STATUS_INVALID;
            ebat_pkg::CODE_NOTFOUND: rsp_status <= ebat_pkg::STATUS_NOTFOUND;
            ebat_pkg::CODE_DETECT: begin
               rsp_status     <= ebat_pkg::STATUS_OK;
               rsp_found      <= 1'b1;
               rsp_anomaly    <= az > {1'b0, zthr_ff};
               rsp_z_score    <= zs;
               rsp_mean_out   <= hit_ent_ff.mean;
               rsp_spread_out <= hit_ent_ff.spread;
               rsp_count_out  <= hit_ent_ff.count;
               rsp_tick_out   <= hit_ent_ff.tick;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // status to the controller
   always_comb begin
      stat.kind_in   = ebat_pkg::kind_type'(req_kind);
      stat.pid_ok_in = (req_process_id != 32'd0);
      stat.key_ok_in = stat.pid_ok_in && ({1'b0, req_indicator} < 9'(NUM_INDICATORS));
      stat.kind      = kind_ff;
      stat.empty     = (used_ff == '0);
      stat.full      = (used_ff >= MAX_CNT);
      stat.hit       = cmp_vld_ff && key_eq;
      stat.scan_last = cmp_vld_ff && (cmp_idx_ff == last_addr);
      stat.div_last  = (div_cnt_ff == ebat_pkg::DIV_CW'(ebat_pkg::DIV_W - 1));
      stat.rm_done   = (rmk_ff >= used_ff);
      stat.rm_match  = (rdata_ff.pid == pid_ff);
      stat.rm_last   = (rmk_ff == used_ff - CW'(1));
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // fill count stays within the table
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= MAX_CNT)
      else $error("fill count beyond table size");

   // appending only happens into a table that has room
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_we && cmd.wr_at == ebat_pkg::WA_USED) |-> (used_ff < MAX_CNT))
      else $error("append into a full table");

   // the partial remainder always stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> (rem_ff < dvs_ff))
      else $error("divider remainder out of range");

endmodule

/* src/ewma_baseline_anomaly_table_unit.sv */
// Clear or a bad key goes straight to the response; update and detect scan the table
// up to the hit, an insert or a miss scans every used entry, a detect hit then runs the
// divider, and a remove walks the table, moving the last entry into each matched slot.
// One item at a time; the next item is taken the cycle after its result is loaded. A
// result held by rsp_ready low stalls a later item in its response state, not the input.
// Synchronous active-high reset empties the table (fill count to zero, no clearing
// pass) and loads the default configuration.
`timescale 1ns / 1ps

module ewma_baseline_anomaly_table_unit #(
   parameter int MAX_ENTRIES    = ebat_pkg::MAX_ENTRIES_DEF,
   parameter int NUM_INDICATORS = ebat_pkg::NUM_INDICATORS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [31:0]        req_process_id,
   input  logic [7:0]         req_indicator,
   input  logic signed [31:0] req_sample,
   input  logic [47:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output logic               rsp_anomaly,
   output logic signed [31:0] rsp_z_score,
   output logic signed [31:0] rsp_mean_out,
   output logic [31:0]        rsp_spread_out,
   output logic [31:0]        rsp_count_out,
   output logic [47:0]        rsp_tick_out
);

   ebat_pkg::cmd_type  cmd;
   ebat_pkg::stat_type stat;

   ebat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ebat_dp #(
      .MAX_ENTRIES    (MAX_ENTRIES),
      .NUM_INDICATORS (NUM_INDICATORS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_kind       (req_kind),
      .req_process_id (req_process_id),
      .req_indicator  (req_indicator),
      .req_sample     (req_sample),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_anomaly    (rsp_anomaly),
      .rsp_z_score    (rsp_z_score),
      .rsp_mean_out   (rsp_mean_out),
      .rsp_spread_out (rsp_spread_out),
      .rsp_count_out  (rsp_count_out),
      .rsp_tick_out   (rsp_tick_out)
   );

endmodule
